[hdl/dtq_pkg.sv]
//------------------------------------------------------------------------------
// dtq_pkg: shared constants of the deadline timer queue
// Operation and result codes, default sizes, and the front-to-back command.
//------------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned TimeBitsDefault = 48;
  localparam int unsigned UsPerMs         = 1000;

  localparam int unsigned OpW      = 3;
  localparam int unsigned TaskW    = 4;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned WaitMsW  = 39;
  localparam int unsigned PendingW = 5;

  localparam logic [OpW-1:0] OP_SCHEDULE   = 3'd0;
  localparam logic [OpW-1:0] OP_WAIT       = 3'd1;
  localparam logic [OpW-1:0] OP_UNSCHEDULE = 3'd2;
  localparam logic [OpW-1:0] OP_RUN        = 3'd3;
  localparam logic [OpW-1:0] OP_DRAIN      = 3'd4;

  localparam logic [KindW-1:0] KIND_DONE     = 3'd0;
  localparam logic [KindW-1:0] KIND_RELEASED = 3'd1;
  localparam logic [KindW-1:0] KIND_NEXT     = 3'd2;
  localparam logic [KindW-1:0] KIND_EMPTY    = 3'd3;
  localparam logic [KindW-1:0] KIND_FULL     = 3'd4;

  // Classified command codes handed from the front to the back.
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_RUN    = 3'd2;
  localparam logic [2:0] CMD_DRAIN  = 3'd3;
  localparam logic [2:0] CMD_NOP    = 3'd4;

endpackage

[hdl/dtq_front.sv]
//------------------------------------------------------------------------------
// dtq_front: command decoder
// Accepts an input beat, computes the wait deadline, and pushes a command.
//------------------------------------------------------------------------------
module dtq_front #(
  parameter int unsigned TimeBits = dtq_pkg::TimeBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dtq_pkg::OpW-1:0]     op_i,
  input  logic [dtq_pkg::TaskW-1:0]   task_id_i,
  input  logic [TimeBits-1:0]         deadline_us_i,
  input  logic [dtq_pkg::DelayW-1:0]  delay_ms_i,
  input  logic [TimeBits-1:0]         now_us_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output logic [2:0]                  cmd_code_o,
  output logic [dtq_pkg::TaskW-1:0]   cmd_task_o,
  output logic [TimeBits-1:0]         cmd_time_o
);

  // Stage 1 holds the beat and forms the product; stage 2 adds and saturates.
  localparam int unsigned ProdW = dtq_pkg::DelayW + 10;
  localparam int unsigned SumW  = (ProdW > TimeBits ? ProdW : TimeBits) + 1;

  logic                       s1_q;
  logic [2:0]                 s1_code_q;
  logic [dtq_pkg::TaskW-1:0]  s1_task_q;
  logic [TimeBits-1:0]        s1_time_q;
  logic                       s1_wait_q;
  logic                       s1_zero_q;
  logic [ProdW-1:0]           s1_prod_q;
  logic                       s2_q;
  logic [2:0]                 s2_code_q;
  logic [dtq_pkg::TaskW-1:0]  s2_task_q;
  logic [TimeBits-1:0]        s2_time_q;
  logic [2:0]                 code_d;
  logic [SumW-1:0]            sum;
  logic [TimeBits-1:0]        wait_dl;
  logic                       adv2;
  logic                       adv1;

  assign adv2     = !s2_q || cmd_ready_i;
  assign adv1     = !s1_q || adv2;
  assign in_ready = adv1;

  always_comb begin
    case (op_i)
      dtq_pkg::OP_SCHEDULE,
      dtq_pkg::OP_WAIT:       code_d = dtq_pkg::CMD_INSERT;
      dtq_pkg::OP_UNSCHEDULE: code_d = dtq_pkg::CMD_REMOVE;
      dtq_pkg::OP_RUN:        code_d = dtq_pkg::CMD_RUN;
      dtq_pkg::OP_DRAIN:      code_d = dtq_pkg::CMD_DRAIN;
      default:                code_d = dtq_pkg::CMD_NOP;
    endcase
  end

  assign sum = SumW'(s1_time_q) + SumW'(s1_prod_q);
  always_comb begin
    if (s1_zero_q) begin
      wait_dl = '0;
    end else if (sum[SumW-1:TimeBits] != '0) begin
      wait_dl = '1;
    end else begin
      wait_dl = sum[TimeBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (adv1) s1_q <= in_valid;
      if (adv2) s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid) begin
      s1_code_q <= code_d;
      s1_task_q <= task_id_i;
      s1_wait_q <= (op_i == dtq_pkg::OP_WAIT);
      s1_zero_q <= (delay_ms_i == '0);
      s1_prod_q <= ProdW'(delay_ms_i) * ProdW'(dtq_pkg::UsPerMs);
      s1_time_q <= (op_i == dtq_pkg::OP_SCHEDULE) ? deadline_us_i : now_us_i;
    end
    if (adv2 && s1_q) begin
      s2_code_q <= s1_code_q;
      s2_task_q <= s1_task_q;
      s2_time_q <= s1_wait_q ? wait_dl : s1_time_q;
    end
  end

  assign cmd_valid_o = s2_q;
  assign cmd_code_o  = s2_code_q;
  assign cmd_task_o  = s2_task_q;
  assign cmd_time_o  = s2_time_q;

endmodule

[hdl/dtq_back.sv]
//------------------------------------------------------------------------------
// dtq_back: sorted store and its sequencer
// Removes and inserts one entry per cycle step and emits result beats.
//------------------------------------------------------------------------------
module dtq_back #(
  parameter int unsigned Depth    = dtq_pkg::DepthDefault,
  parameter int unsigned TimeBits = dtq_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  logic [2:0]                     cmd_code_i,
  input  logic [dtq_pkg::TaskW-1:0]      cmd_task_i,
  input  logic [TimeBits-1:0]            cmd_time_i,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dtq_pkg::KindW-1:0]      kind_o,
  output logic [dtq_pkg::TaskW-1:0]      task_id_out_o,
  output logic [dtq_pkg::WaitMsW-1:0]    wait_ms_o,
  output logic [dtq_pkg::PendingW-1:0]   pending_o,
  output logic                           last_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  // The divide by 1000 runs a byte per cycle. Each step divides a value
  // below 1000 * 256: it is shifted down by three and then divided by 125
  // through a reciprocal multiply, which is exact for 15-bit operands.
  localparam int unsigned DigW     = 8;
  localparam int unsigned Steps    = (TimeBits + DigW - 1) / DigW;
  localparam int unsigned PadW     = Steps * DigW;
  localparam int unsigned RemW     = 10;
  localparam int unsigned CurW     = RemW + DigW;
  localparam int unsigned StepW    = $clog2(Steps + 1);
  localparam logic [15:0] Recip125 = 16'd33555;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIND   = 3'd1;
  localparam logic [2:0] ST_INS    = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // The store is a register file: each entry is shifted by its neighbor
  // in parallel, so the whole insert or remove shift is done in one state.
  logic [dtq_pkg::TaskW-1:0] task_q [Depth];
  logic [TimeBits-1:0]       dl_q   [Depth];
  logic [CntW-1:0]           cnt_q;
  logic [2:0]                st_q;
  logic [2:0]                code_q;
  logic [dtq_pkg::TaskW-1:0] tid_q;
  logic [TimeBits-1:0]       tm_q;
  logic [RemW-1:0]           rem_q;
  logic [PadW-1:0]           div_q;
  logic [StepW-1:0]          dcnt_q;

  logic                      ov_q;
  logic [dtq_pkg::KindW-1:0] ok_q;
  logic [dtq_pkg::TaskW-1:0] ot_q;
  logic [dtq_pkg::WaitMsW-1:0] ow_q;
  logic [dtq_pkg::PendingW-1:0] op_q;
  logic                      ol_q;

  logic [Depth-1:0] hit;
  logic [Depth-1:0] after;
  logic             found;
  logic [IdxW-1:0]  hit_idx;
  logic [IdxW-1:0]  ins_idx;
  logic [CntW-1:0]  ins_pos;
  logic             out_free;
  logic [CurW-1:0]  cur;
  logic [29:0]      prod;
  logic [DigW-1:0]  digit;
  logic [RemW-1:0]  rem_next;

  assign out_free = !ov_q || out_ready;

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    ins_pos = cnt_q;
    for (int i = 0; i < Depth; i++) begin
      hit[i]   = (CntW'(i) < cnt_q) && (task_q[i] == tid_q);
      after[i] = (CntW'(i) < cnt_q) && (dl_q[i] > tm_q);
    end
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found   = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (after[i]) ins_pos = CntW'(i);
    end
    ins_idx = ins_pos[IdxW-1:0];
  end

  assign cur      = {rem_q, div_q[PadW-1 -: DigW]};
  assign prod     = 30'(cur[CurW-1:3]) * 30'(Recip125);
  assign digit    = prod[29:22];
  assign rem_next = RemW'(cur - CurW'(digit) * CurW'(dtq_pkg::UsPerMs));

  // A new command waits until the previous result beat has left.
  assign cmd_ready_o = (st_q == ST_IDLE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (ov_q && out_ready) ov_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            case (cmd_code_i)
              dtq_pkg::CMD_INSERT,
              dtq_pkg::CMD_REMOVE: st_q <= ST_FIND;
              dtq_pkg::CMD_RUN,
              dtq_pkg::CMD_DRAIN:  st_q <= ST_RUN;
              default:             st_q <= ST_EMIT;
            endcase
          end
        end
        ST_FIND: begin
          if (found) cnt_q <= cnt_q - 1'b1;
          if (code_q == dtq_pkg::CMD_INSERT) st_q <= ST_INS;
          else st_q <= ST_EMIT;
        end
        ST_INS: begin
          if (cnt_q != CntW'(Depth)) cnt_q <= cnt_q + 1'b1;
          st_q <= ST_EMIT;
        end
        ST_RUN: begin
          if (out_free) begin
            ov_q <= 1'b1;
            if (cnt_q != '0 &&
                (code_q == dtq_pkg::CMD_DRAIN || dl_q[0] <= tm_q)) begin
              cnt_q <= cnt_q - 1'b1;
            end else if (code_q == dtq_pkg::CMD_RUN && cnt_q != '0) begin
              ov_q <= 1'b0;
              st_q <= ST_DIV;
            end else begin
              st_q <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (dcnt_q == '0 && out_free) begin
            ov_q <= 1'b1;
            st_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          code_q <= cmd_code_i;
          tid_q  <= cmd_task_i;
          tm_q   <= cmd_time_i;
          ok_q   <= dtq_pkg::KIND_DONE;
        end
      end
      ST_FIND: begin
        if (found) begin
          for (int i = 0; i < Depth - 1; i++) begin
            if (IdxW'(i) >= hit_idx) begin
              task_q[i] <= task_q[i+1];
              dl_q[i]   <= dl_q[i+1];
            end
          end
        end
      end
      ST_INS: begin
        if (cnt_q == CntW'(Depth)) begin
          ok_q <= dtq_pkg::KIND_FULL;
        end else begin
          for (int i = 1; i < Depth; i++) begin
            if (IdxW'(i) > ins_idx) begin
              task_q[i] <= task_q[i-1];
              dl_q[i]   <= dl_q[i-1];
            end
          end
          task_q[ins_idx] <= tid_q;
          dl_q[ins_idx]   <= tm_q;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          ow_q <= '0;
          ot_q <= '0;
          if (cnt_q != '0 &&
              (code_q == dtq_pkg::CMD_DRAIN || dl_q[0] <= tm_q)) begin
            ok_q <= dtq_pkg::KIND_RELEASED;
            ot_q <= task_q[0];
            ol_q <= 1'b0;
            op_q <= dtq_pkg::PendingW'(cnt_q - 1'b1);
            for (int i = 0; i < Depth - 1; i++) begin
              task_q[i] <= task_q[i+1];
              dl_q[i]   <= dl_q[i+1];
            end
          end else begin
            ol_q <= 1'b1;
            op_q <= dtq_pkg::PendingW'(cnt_q);
            if (code_q == dtq_pkg::CMD_DRAIN) ok_q <= dtq_pkg::KIND_DONE;
            else if (cnt_q == '0) ok_q <= dtq_pkg::KIND_EMPTY;
            else begin
              ok_q   <= dtq_pkg::KIND_NEXT;
              div_q  <= PadW'(dl_q[0] - tm_q);
              rem_q  <= '0;
              dcnt_q <= StepW'(Steps);
            end
          end
        end
      end
      ST_DIV: begin
        if (dcnt_q != '0) begin
          dcnt_q <= dcnt_q - 1'b1;
          div_q  <= {div_q[PadW-DigW-1:0], digit};
          rem_q  <= rem_next;
        end else begin
          ow_q <= dtq_pkg::WaitMsW'(div_q);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ot_q <= '0;
          ow_q <= '0;
          ol_q <= 1'b1;
          op_q <= dtq_pkg::PendingW'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = ov_q;
  assign kind_o        = ok_q;
  assign task_id_out_o = ot_q;
  assign wait_ms_o     = ow_q;
  assign pending_o     = op_q;
  assign last_o        = ol_q;

endmodule

[hdl/deadline_timer_queue.sv]
//------------------------------------------------------------------------------
// deadline_timer_queue: sorted deadline timer queue
// Keeps task ids ordered by wake deadline; releases due ones, or all on drain.
//------------------------------------------------------------------------------
//  Channel | Handshake              | Beat
//  input   | in_valid / in_ready    | op, task id, deadline, delay, now
//  output  | out_valid / out_ready  | kind, task id, wait ms, pending, last
//
// A front stage decodes each input beat and computes the wait deadline in
// two pipelined steps, then hands a command to the back sequencer, which
// owns the sorted store. In the back, schedule and wait pass through find,
// insert and emit, and unschedule through find and emit; run and drain
// take the command and then give one result beat each time the output is
// free, and a run that reports time to the next deadline then divides by
// 1000 a byte at a time. Reset clears the entry count, the state and the
// valid flags only; no clearing pass is needed. A stalled output holds the
// back, and the front keeps accepting up to two beats meanwhile.
module deadline_timer_queue #(
  parameter int unsigned DEPTH     = dtq_pkg::DepthDefault,
  parameter int unsigned TIME_BITS = dtq_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtq_pkg::OpW-1:0]       op_i,
  input  logic [dtq_pkg::TaskW-1:0]     task_id_i,
  input  logic [TIME_BITS-1:0]          deadline_us_i,
  input  logic [dtq_pkg::DelayW-1:0]    delay_ms_i,
  input  logic [TIME_BITS-1:0]          now_us_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtq_pkg::KindW-1:0]     kind_o,
  output logic [dtq_pkg::TaskW-1:0]     task_id_out_o,
  output logic [dtq_pkg::WaitMsW-1:0]   wait_ms_o,
  output logic [dtq_pkg::PendingW-1:0]  pending_o,
  output logic                          last_o
);

  logic                       cmd_valid;
  logic                       cmd_ready;
  logic [2:0]                 cmd_code;
  logic [dtq_pkg::TaskW-1:0]  cmd_task;
  logic [TIME_BITS-1:0]       cmd_time;

  dtq_front #(.TimeBits(TIME_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .op_i, .task_id_i, .deadline_us_i, .delay_ms_i, .now_us_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .cmd_code_o(cmd_code), .cmd_task_o(cmd_task), .cmd_time_o(cmd_time)
  );

  dtq_back #(.Depth(DEPTH), .TimeBits(TIME_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_code_i(cmd_code), .cmd_task_i(cmd_task), .cmd_time_i(cmd_time),
    .out_valid, .out_ready, .kind_o, .task_id_out_o, .wait_ms_o,
    .pending_o, .last_o
  );

endmodule
